// ===== hdl/bucl_pkg.sv =====
// ----------------------------------------------------------------------------
// bucl_pkg
// Shared types and codes for the bounded unique compacting list.
// ----------------------------------------------------------------------------
`default_nettype none

package bucl_pkg;

    localparam logic [2:0] CMD_ADD        = 3'd0;
    localparam logic [2:0] CMD_REMOVE_AT  = 3'd1;
    localparam logic [2:0] CMD_REMOVE_HDL = 3'd2;
    localparam logic [2:0] CMD_READ       = 3'd3;
    localparam logic [2:0] CMD_CLEAR      = 3'd4;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_MISS  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    // Width that holds any position and any count up to the largest list.
    localparam int POS_CMP_BITS = 7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] item_handle;
        logic [5:0]  position;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] read_handle;
        logic        read_valid;
        logic [5:0]  entry_count;
    } t_out;

    typedef struct packed {
        logic live;
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== hdl/bucl_cell.sv =====
// ----------------------------------------------------------------------------
// bucl_cell
// One list slot: holds a handle, compares it, and takes its upper neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module bucl_cell #(
    parameter int HANDLE_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire bucl_pkg::t_cell_ctl    i_ctl,
    input  wire logic [HANDLE_BITS-1:0] i_handle,
    input  wire logic [HANDLE_BITS-1:0] i_next,
    output logic      [HANDLE_BITS-1:0] o_entry,
    output logic                        o_match
);

    logic [HANDLE_BITS-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_handle;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;
    assign o_match = i_ctl.live && (r_entry == i_handle);

endmodule

`default_nettype wire

// ===== hdl/bounded_unique_compacting_list_top.sv =====
// ----------------------------------------------------------------------------
// bounded_unique_compacting_list_top
// Ordered list of distinct handles held in a row of slot cells.
// An accepted result is registered and shown in the next cycle. Throughput:
// one transaction per cycle unless stalled; slots compare and shift at once.
// Reset clears the count and the output valid flag; slot contents and the
// output data register stay as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_unique_compacting_list_top #(
    parameter int CAPACITY    = 32,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire bucl_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output bucl_pkg::t_out      o_out_data
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IW    = $clog2(CAPACITY);
    localparam int XW    = bucl_pkg::POS_CMP_BITS;
    localparam int HB_IN = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_out_valid;
    bucl_pkg::t_out         r_out;
    bucl_pkg::t_out         n_out;

    logic                   w_acc;
    logic [HANDLE_BITS-1:0] w_handle;
    logic [XW-1:0]          w_cnt;
    logic [XW-1:0]          w_pos;
    logic [HANDLE_BITS-1:0] w_entry [CAPACITY];
    logic [CAPACITY-1:0]    w_hit;
    logic                   w_any;
    logic [XW-1:0]          w_hit_idx;
    logic [XW-1:0]          w_rd_pos;
    logic [HANDLE_BITS-1:0] w_rd_entry;
    logic [2:0]             w_status;
    logic                   w_add_ok;
    logic                   w_drop;
    logic [XW-1:0]          w_drop_pos;
    logic                   w_clear;
    logic                   w_rd_valid;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_handle   = HANDLE_BITS'(i_in_data.item_handle[HB_IN-1:0]);
    assign w_cnt      = XW'(r_count);
    assign w_pos      = XW'(i_in_data.position);

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        bucl_pkg::t_cell_ctl    w_ctl;
        logic [HANDLE_BITS-1:0] w_next;

        assign w_ctl.live  = XW'(k) < w_cnt;
        assign w_ctl.load  = w_acc && w_add_ok && (XW'(k) == w_cnt);
        assign w_ctl.shift = w_acc && w_drop && (XW'(k) >= w_drop_pos);

        if (k == CAPACITY - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_entry[k+1];
        end

        bucl_cell #(
            .HANDLE_BITS(HANDLE_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_handle (w_handle),
            .i_next   (w_next),
            .o_entry  (w_entry[k]),
            .o_match  (w_hit[k])
        );
    end

    assign w_any = |w_hit;

    always_comb begin
        w_hit_idx = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (w_hit[k]) begin
                w_hit_idx = w_hit_idx | XW'(k);
            end
        end
    end

    assign w_rd_pos   = (w_pos >= w_cnt) ? (w_cnt - XW'(1)) : w_pos;
    assign w_rd_entry = w_entry[w_rd_pos[IW-1:0]];

    always_comb begin
        w_status   = bucl_pkg::ST_OK;
        w_add_ok   = 1'b0;
        w_drop     = 1'b0;
        w_drop_pos = w_pos;
        w_clear    = 1'b0;
        w_rd_valid = 1'b0;
        unique case (i_in_data.cmd)
            bucl_pkg::CMD_ADD: begin
                if (w_any) begin
                    w_status = bucl_pkg::ST_DUP;
                end else if (r_count >= CW'(CAPACITY)) begin
                    w_status = bucl_pkg::ST_FULL;
                end else begin
                    w_add_ok = 1'b1;
                end
            end
            bucl_pkg::CMD_REMOVE_AT: begin
                if (w_pos < w_cnt) begin
                    w_drop = 1'b1;
                end else begin
                    w_status = bucl_pkg::ST_MISS;
                end
            end
            bucl_pkg::CMD_REMOVE_HDL: begin
                if (w_any) begin
                    w_drop     = 1'b1;
                    w_drop_pos = w_hit_idx;
                end else begin
                    w_status = bucl_pkg::ST_MISS;
                end
            end
            bucl_pkg::CMD_READ: begin
                if (r_count == '0) begin
                    w_status = bucl_pkg::ST_EMPTY;
                end else begin
                    w_rd_valid = 1'b1;
                end
            end
            bucl_pkg::CMD_CLEAR: begin
                w_clear = 1'b1;
            end
            default: begin
                w_status = bucl_pkg::ST_MISS;
            end
        endcase
    end

    always_comb begin
        if (w_clear) begin
            n_count = '0;
        end else if (w_add_ok) begin
            n_count = r_count + CW'(1);
        end else if (w_drop) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
        n_out.status      = w_status;
        n_out.read_handle = w_rd_valid ? 16'(w_rd_entry) : 16'd0;
        n_out.read_valid  = w_rd_valid;
        n_out.entry_count = 6'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("List count exceeds capacity.");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> o_out_valid)
        else $error("Accepted transaction produced no result.");

    a_read_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.read_valid || o_out_data.status == bucl_pkg::ST_OK))
        else $error("Valid read handle reported with an error status.");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("Handle matches more than one live slot.");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded unique compacting list.
// A short table of directed commands covers the empty, duplicate, clamp,
// miss and unused-code behavior. Random command sequences follow: fills to
// capacity, drains and mixed churn. A local model of the list predicts every
// reply, and a scoreboard compares each reply field by field. Both sides idle
// and stall at random, with one quiet stretch and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CAP              = 32;
    localparam int          ITEMS            = 1700;
    localparam int          HOLD_CYCLES      = 400;
    localparam logic [2:0]  CMD_FIRST_UNUSED = 3'd5;
    localparam logic [2:0]  CMD_MID_UNUSED   = 3'd6;
    localparam logic [2:0]  CMD_LAST_CODE    = 3'd7;

    typedef struct {
        bucl_pkg::t_in  stim;
        bit             typed;
        bucl_pkg::t_out want;
    } t_dir_row;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    bucl_pkg::t_in  i_in_data   = '0;
    logic           i_out_stall = 1'b0;
    logic           o_in_stall;
    logic           o_out_valid;
    bucl_pkg::t_out o_out_data;

    logic [15:0]    list_q [CAP];
    int             list_len = 0;
    bucl_pkg::t_out replies_due [$];
    t_dir_row       plan [$];

    int  sent       = 0;
    int  checked    = 0;
    int  fail_cnt   = 0;
    int  full_hits  = 0;
    int  dup_hits   = 0;
    int  clamp_hits = 0;
    bit  calm       = 1'b0;
    bit  hold_go    = 1'b0;

    bounded_unique_compacting_list_top #(
        .CAPACITY    (CAP),
        .HANDLE_BITS (16)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int list_find(input logic [15:0] h);
        for (int k = 0; k < list_len; k++) begin
            if (list_q[k] == h) begin
                return k;
            end
        end
        return -1;
    endfunction

    function automatic void list_drop(input int pos);
        list_len--;
        for (int k = pos; k < list_len; k++) begin
            list_q[k] = list_q[k + 1];
        end
    endfunction

    function automatic bucl_pkg::t_out apply_list_cmd(input bucl_pkg::t_in c);
        bucl_pkg::t_out r;
        int             hit;
        int             p;
        r = '0;
        r.status = bucl_pkg::ST_OK;
        case (c.cmd)
            bucl_pkg::CMD_ADD: begin
                hit = list_find(c.item_handle);
                if (hit >= 0) begin
                    r.status = bucl_pkg::ST_DUP;
                    dup_hits++;
                end else if (list_len >= CAP) begin
                    r.status = bucl_pkg::ST_FULL;
                    full_hits++;
                end else begin
                    list_q[list_len] = c.item_handle;
                    list_len++;
                end
            end
            bucl_pkg::CMD_REMOVE_AT: begin
                if (int'(c.position) < list_len) begin
                    list_drop(int'(c.position));
                end else begin
                    r.status = bucl_pkg::ST_MISS;
                end
            end
            bucl_pkg::CMD_REMOVE_HDL: begin
                hit = list_find(c.item_handle);
                if (hit >= 0) begin
                    list_drop(hit);
                end else begin
                    r.status = bucl_pkg::ST_MISS;
                end
            end
            bucl_pkg::CMD_READ: begin
                if (list_len == 0) begin
                    r.status = bucl_pkg::ST_EMPTY;
                end else begin
                    p = int'(c.position);
                    if (p >= list_len) begin
                        p = list_len - 1;
                        clamp_hits++;
                    end
                    r.read_handle = list_q[p];
                    r.read_valid  = 1'b1;
                end
            end
            bucl_pkg::CMD_CLEAR: begin
                list_len = 0;
            end
            default: begin
                r.status = bucl_pkg::ST_MISS;
            end
        endcase
        r.entry_count = 6'(list_len);
        return r;
    endfunction

    function automatic bucl_pkg::t_in mk_cmd(input logic [2:0] c, input logic [15:0] h,
                                             input logic [5:0] p);
        bucl_pkg::t_in t;
        t.cmd         = c;
        t.item_handle = h;
        t.position    = p;
        return t;
    endfunction

    function automatic t_dir_row row(input logic [2:0] c, input logic [15:0] h,
                                     input logic [5:0] p, input bit typed,
                                     input logic [2:0] st, input logic [15:0] rh,
                                     input logic rv, input logic [5:0] n);
        t_dir_row d;
        d.stim              = mk_cmd(c, h, p);
        d.typed             = typed;
        d.want.status       = st;
        d.want.read_handle  = rh;
        d.want.read_valid   = rv;
        d.want.entry_count  = n;
        return d;
    endfunction

    function automatic logic [15:0] pick_handle();
        if (list_len != 0 && $urandom_range(99) < 40) begin
            return list_q[$urandom_range(list_len - 1)];
        end
        if ($urandom_range(99) < 40) begin
            return 16'($urandom_range(47));
        end
        return 16'($urandom);
    endfunction

    function automatic logic [5:0] pick_position();
        if (list_len != 0 && $urandom_range(99) < 70) begin
            return 6'($urandom_range(list_len - 1));
        end
        return 6'($urandom_range(63));
    endfunction

    function automatic bucl_pkg::t_in pick_churn();
        int          w;
        logic [2:0]  c;
        w = $urandom_range(99);
        if (w < 30) begin
            c = bucl_pkg::CMD_ADD;
        end else if (w < 45) begin
            c = bucl_pkg::CMD_REMOVE_AT;
        end else if (w < 60) begin
            c = bucl_pkg::CMD_REMOVE_HDL;
        end else if (w < 88) begin
            c = bucl_pkg::CMD_READ;
        end else if (w < 92) begin
            c = bucl_pkg::CMD_CLEAR;
        end else begin
            c = 3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
        end
        return mk_cmd(c, pick_handle(), pick_position());
    endfunction

    task automatic send(input bucl_pkg::t_in item, input bit typed = 1'b0,
                        input bucl_pkg::t_out want = '0);
        int             gap;
        bucl_pkg::t_out got;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < 36) begin
                gap++;
            end
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        got = apply_list_cmd(item);
        replies_due.push_back(typed ? want : got);
        sent++;
        if (sent == 400) begin
            hold_go = 1'b1;
        end
        calm = (sent >= 700 && sent < 1000);
    endtask

    task automatic cmp_field(input string name, input int unsigned want,
                             input int unsigned got);
        if (want != got) begin
            $error("%s expected %0d (0x%0h) actual %0d (0x%0h)", name, want, want, got, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : reply_check
        bucl_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                $error("reply transaction with no command outstanding");
                fail_cnt++;
            end else begin
                want = replies_due.pop_front();
                checked++;
                cmp_field("status", want.status, o_out_data.status);
                cmp_field("read_handle", want.read_handle, o_out_data.read_handle);
                cmp_field("read_valid", want.read_valid, o_out_data.read_valid);
                cmp_field("entry_count", want.entry_count, o_out_data.entry_count);
            end
        end
    end

    initial begin : out_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (calm) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < 36);
            end
        end
    end

    initial begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : in_side
        int seq;
        int kind;
        int guard;

        plan.push_back(row(bucl_pkg::CMD_READ, 16'h0000, 6'd0, 1,
                           bucl_pkg::ST_EMPTY, 16'h0000, 0, 6'd0));
        plan.push_back(row(bucl_pkg::CMD_REMOVE_AT, 16'h0000, 6'd63, 1,
                           bucl_pkg::ST_MISS, 16'h0000, 0, 6'd0));
        plan.push_back(row(bucl_pkg::CMD_REMOVE_HDL, 16'hFFFF, 6'd0, 1,
                           bucl_pkg::ST_MISS, 16'h0000, 0, 6'd0));
        plan.push_back(row(bucl_pkg::CMD_ADD, 16'h0000, 6'd0, 1,
                           bucl_pkg::ST_OK, 16'h0000, 0, 6'd1));
        plan.push_back(row(bucl_pkg::CMD_ADD, 16'hFFFF, 6'd63, 1,
                           bucl_pkg::ST_OK, 16'h0000, 0, 6'd2));
        plan.push_back(row(bucl_pkg::CMD_ADD, 16'h0000, 6'd0, 1,
                           bucl_pkg::ST_DUP, 16'h0000, 0, 6'd2));
        plan.push_back(row(bucl_pkg::CMD_READ, 16'h0000, 6'd63, 1,
                           bucl_pkg::ST_OK, 16'hFFFF, 1, 6'd2));
        plan.push_back(row(bucl_pkg::CMD_READ, 16'hFFFF, 6'd0, 1,
                           bucl_pkg::ST_OK, 16'h0000, 1, 6'd2));
        plan.push_back(row(CMD_FIRST_UNUSED, 16'hFFFF, 6'd63, 1,
                           bucl_pkg::ST_MISS, 16'h0000, 0, 6'd2));
        plan.push_back(row(CMD_LAST_CODE, 16'h0000, 6'd0, 1,
                           bucl_pkg::ST_MISS, 16'h0000, 0, 6'd2));
        plan.push_back(row(bucl_pkg::CMD_REMOVE_AT, 16'h0000, 6'd2, 1,
                           bucl_pkg::ST_MISS, 16'h0000, 0, 6'd2));
        plan.push_back(row(bucl_pkg::CMD_ADD, 16'h8001, 6'd0, 0,
                           bucl_pkg::ST_OK, 16'h0000, 0, 6'd0));
        plan.push_back(row(bucl_pkg::CMD_REMOVE_AT, 16'h0000, 6'd0, 0,
                           bucl_pkg::ST_OK, 16'h0000, 0, 6'd0));
        plan.push_back(row(bucl_pkg::CMD_READ, 16'h0000, 6'd0, 0,
                           bucl_pkg::ST_OK, 16'h0000, 0, 6'd0));
        plan.push_back(row(bucl_pkg::CMD_REMOVE_HDL, 16'h1234, 6'd0, 1,
                           bucl_pkg::ST_MISS, 16'h0000, 0, 6'd2));
        plan.push_back(row(bucl_pkg::CMD_REMOVE_HDL, 16'hFFFF, 6'd0, 0,
                           bucl_pkg::ST_OK, 16'h0000, 0, 6'd0));
        plan.push_back(row(bucl_pkg::CMD_READ, 16'h0000, 6'd1, 0,
                           bucl_pkg::ST_OK, 16'h0000, 0, 6'd0));
        plan.push_back(row(bucl_pkg::CMD_CLEAR, 16'hFFFF, 6'd63, 1,
                           bucl_pkg::ST_OK, 16'h0000, 0, 6'd0));
        plan.push_back(row(bucl_pkg::CMD_READ, 16'h0000, 6'd5, 1,
                           bucl_pkg::ST_EMPTY, 16'h0000, 0, 6'd0));
        plan.push_back(row(CMD_MID_UNUSED, 16'h0000, 6'd0, 1,
                           bucl_pkg::ST_MISS, 16'h0000, 0, 6'd0));
        plan.push_back(row(bucl_pkg::CMD_ADD, 16'h5555, 6'd0, 0,
                           bucl_pkg::ST_OK, 16'h0000, 0, 6'd0));
        plan.push_back(row(bucl_pkg::CMD_ADD, 16'hAAAA, 6'd0, 0,
                           bucl_pkg::ST_OK, 16'h0000, 0, 6'd0));
        plan.push_back(row(bucl_pkg::CMD_REMOVE_HDL, 16'h5555, 6'd0, 0,
                           bucl_pkg::ST_OK, 16'h0000, 0, 6'd0));
        plan.push_back(row(bucl_pkg::CMD_READ, 16'h0000, 6'd63, 0,
                           bucl_pkg::ST_OK, 16'h0000, 0, 6'd0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            send(plan[i].stim, plan[i].typed, plan[i].want);
        end

        seq = 0;
        while (sent < ITEMS) begin
            kind = (seq == 0) ? 0 : $urandom_range(99);
            seq++;
            if (kind < 15) begin
                send(mk_cmd(bucl_pkg::CMD_CLEAR, 16'($urandom), 6'($urandom_range(63))));
                guard = 0;
                while (list_len < CAP && guard < 4 * CAP) begin
                    send(mk_cmd(bucl_pkg::CMD_ADD, 16'($urandom), 6'($urandom_range(63))));
                    guard++;
                end
                send(mk_cmd(bucl_pkg::CMD_ADD, 16'($urandom), 6'($urandom_range(63))));
                send(mk_cmd(bucl_pkg::CMD_ADD, list_q[$urandom_range(list_len - 1)],
                            6'($urandom_range(63))));
                send(mk_cmd(bucl_pkg::CMD_READ, 16'($urandom),
                            6'($urandom_range(CAP, 63))));
            end else if (kind < 27) begin
                while (list_len > 0) begin
                    if ($urandom_range(1) == 0) begin
                        send(mk_cmd(bucl_pkg::CMD_REMOVE_AT, 16'($urandom),
                                    6'($urandom_range(list_len - 1))));
                    end else begin
                        send(mk_cmd(bucl_pkg::CMD_REMOVE_HDL,
                                    list_q[$urandom_range(list_len - 1)],
                                    6'($urandom_range(63))));
                    end
                end
                send(mk_cmd(bucl_pkg::CMD_READ, 16'($urandom), 6'($urandom_range(63))));
                send(mk_cmd(bucl_pkg::CMD_REMOVE_AT, 16'($urandom),
                            6'($urandom_range(63))));
            end else begin
                repeat (20) send(pick_churn());
            end
        end

        i_in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Ran %0d commands and checked %0d replies.", sent, checked);
        $display("Hit full %0d times, duplicates %0d times, clamped reads %0d times.",
                 full_hits, dup_hits, clamp_hits);
        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
